[design/mpq_pkg.sv]
// Shared types and constants for the max priority queue.
package mpq_pkg;

    localparam int OCC_W = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_WAIT,
        S_SHIFT_INIT,
        S_SHIFT
    } t_state;

    typedef struct packed {
        logic do_insert;
        logic do_full;
        logic do_empty;
        logic scan_init;
        logic scan_issue;
        logic shift_init;
        logic shift_issue;
        logic do_remove;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic scan_last;
        logic shift_end;
    } t_dp_stat;

endpackage

[design/mpq_ctrl.sv]
// Controller state machine sequencing insert, scan and shift of the queue.
module mpq_ctrl
    import mpq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     i_operation,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    if (t_op'(i_operation) == OP_REMOVE) begin
                        if (i_stat.empty) begin
                            o_cmd.do_empty = 1'b1;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                    end else if (i_stat.full) begin
                        o_cmd.do_full = 1'b1;
                    end else begin
                        o_cmd.do_insert = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT: begin
                n_state = S_SHIFT_INIT;
            end
            S_SHIFT_INIT: begin
                o_cmd.shift_init = 1'b1;
                n_state          = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_stat.shift_end) begin
                    o_cmd.do_remove = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.shift_issue = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[design/mpq_datapath.sv]
// Datapath: entry memory, count, scan for the best entry, shift and result registers.
module mpq_datapath
    import mpq_pkg::*;
#(
    parameter int DEPTH          = 16,
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic [DATA_WIDTH-1:0]     i_entry_data,
    input  logic [PRIORITY_WIDTH-1:0] i_priority_req,
    output t_dp_stat                  o_stat,
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic [DATA_WIDTH-1:0]     o_removed_data,
    output logic [PRIORITY_WIDTH-1:0] o_removed_priority,
    output logic [OCC_W-1:0]          o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0]     mem_data [DEPTH];
    logic [PRIORITY_WIDTH-1:0] mem_pri  [DEPTH];

    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_idx;
    logic                      r_pipe_vld;
    logic                      r_pipe_shift;
    logic [AW-1:0]             r_pipe_idx;
    logic [DATA_WIDTH-1:0]     r_rd_data;
    logic [PRIORITY_WIDTH-1:0] r_rd_pri;
    logic [AW-1:0]             r_best;
    logic [DATA_WIDTH-1:0]     r_best_data;
    logic [PRIORITY_WIDTH-1:0] r_best_pri;

    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [DATA_WIDTH-1:0]     wr_data;
    logic [PRIORITY_WIDTH-1:0] wr_pri;
    logic                      take_best;

    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.scan_last = (r_idx == r_count - CW'(1));
    assign o_stat.shift_end = (r_idx >= r_count);

    assign take_best = r_pipe_vld && !r_pipe_shift
                       && ((r_pipe_idx == '0) || (r_rd_pri > r_best_pri));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[AW-1:0];
        wr_data = i_entry_data;
        wr_pri  = i_priority_req;
        if (i_cmd.do_insert) begin
            wr_en = 1'b1;
        end else if (r_pipe_vld && r_pipe_shift) begin
            wr_en   = 1'b1;
            wr_addr = r_pipe_idx - AW'(1);
            wr_data = r_rd_data;
            wr_pri  = r_rd_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_data[wr_addr] <= wr_data;
            mem_pri[wr_addr]  <= wr_pri;
        end
        r_rd_data <= mem_data[r_idx[AW-1:0]];
        r_rd_pri  <= mem_pri[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (take_best) begin
            r_best      <= r_pipe_idx;
            r_best_data <= r_rd_data;
            r_best_pri  <= r_rd_pri;
        end
        r_pipe_idx <= r_idx[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_idx        <= '0;
            r_pipe_vld   <= 1'b0;
            r_pipe_shift <= 1'b0;
        end else begin
            r_pipe_vld   <= i_cmd.scan_issue | i_cmd.shift_issue;
            r_pipe_shift <= i_cmd.shift_issue;
            priority if (i_cmd.scan_init) begin
                r_idx <= '0;
            end else if (i_cmd.shift_init) begin
                r_idx <= CW'(r_best) + CW'(1);
            end else if (i_cmd.scan_issue || i_cmd.shift_issue) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.do_insert) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.do_remove) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.do_insert | i_cmd.do_full | i_cmd.do_empty | i_cmd.do_remove;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.do_insert) begin
            o_status           <= ST_INSERTED;
            o_removed_data     <= '0;
            o_removed_priority <= '0;
            o_occupancy        <= OCC_W'(r_count + CW'(1));
        end else if (i_cmd.do_full) begin
            o_status           <= ST_FULL;
            o_removed_data     <= '0;
            o_removed_priority <= '0;
            o_occupancy        <= OCC_W'(r_count);
        end else if (i_cmd.do_empty) begin
            o_status           <= ST_EMPTY;
            o_removed_data     <= '0;
            o_removed_priority <= '0;
            o_occupancy        <= OCC_W'(r_count);
        end else if (i_cmd.do_remove) begin
            o_status           <= ST_REMOVED;
            o_removed_data     <= r_best_data;
            o_removed_priority <= r_best_pri;
            o_occupancy        <= OCC_W'(r_count - CW'(1));
        end else begin
            o_status           <= ST_INSERTED;
            o_removed_data     <= '0;
            o_removed_priority <= '0;
            o_occupancy        <= OCC_W'(r_count);
        end
    end

endmodule

[design/max_priority_queue.sv]
// Top level of the bounded max priority queue.
// An insert leaves busy low, and the result strobes on o_valid in the next
// cycle. A remove on an empty queue, or an insert into a full one, is handled alike.
// A remove of a held entry reads the entry memory, which has one read and one write port.
// It scans the n held entries for the highest priority (oldest wins among equals), lets
// the choice settle, moves the younger entries down over slot k, and finishes; busy stays
// high throughout, and the result strobes in the same cycle in which busy falls. Each
// result is on the outputs for one cycle only and must be captured then; the receiver
// cannot stall the block.
module max_priority_queue
    import mpq_pkg::*;
#(
    parameter int DEPTH          = 16,
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_operation,
    input  logic [DATA_WIDTH-1:0]     i_entry_data,
    input  logic [PRIORITY_WIDTH-1:0] i_priority_req,
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic [DATA_WIDTH-1:0]     o_removed_data,
    output logic [PRIORITY_WIDTH-1:0] o_removed_priority,
    output logic [OCC_W-1:0]          o_occupancy
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .busy        (busy)
    );

    mpq_datapath #(
        .DEPTH          (DEPTH),
        .DATA_WIDTH     (DATA_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_entry_data       (i_entry_data),
        .i_priority_req     (i_priority_req),
        .o_stat             (stat),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_removed_data     (o_removed_data),
        .o_removed_priority (o_removed_priority),
        .o_occupancy        (o_occupancy)
    );

endmodule
